// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define TVME_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define TVME_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/tvme_pkg.sv =====
// Shared types, codes and pairing tables of the two-value mean engine.
// No dependencies.
package tvme_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int COUNT_WIDTH = 7;

    localparam logic [3:0] OP_QM  = 4'd0;
    localparam logic [3:0] OP_AM  = 4'd1;
    localparam logic [3:0] OP_GM  = 4'd2;
    localparam logic [3:0] OP_HM  = 4'd3;
    localparam logic [3:0] OP_MM  = 4'd4;
    localparam logic [3:0] OP_AGM = 4'd5;
    localparam logic [3:0] OP_GHM = 4'd6;
    localparam logic [3:0] OP_AHM = 4'd7;
    localparam logic [3:0] OP_QAM = 4'd8;
    localparam logic [3:0] OP_QGM = 4'd9;
    localparam logic [3:0] OP_QMM = 4'd10;
    localparam logic [3:0] OP_GMM = 4'd11;

    localparam logic [COUNT_WIDTH-1:0] MAX_ROUNDS   = 7'd99;
    localparam logic [COUNT_WIDTH-1:0] RESET_ROUNDS = 7'd24;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] operand_x;
        logic [VALUE_WIDTH-1:0] operand_y;
        logic [3:0]             operation;
    } in_beat_t;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] mean_value;
        logic                   input_error;
    } out_beat_t;

    // First basic mean of a compound code.
    function automatic logic [3:0] first_mean(input logic [3:0] op);
        logic [3:0] m;
        case (op)
            OP_AGM:  m = OP_AM;
            OP_GHM:  m = OP_GM;
            OP_AHM:  m = OP_AM;
            OP_QAM:  m = OP_QM;
            OP_QGM:  m = OP_QM;
            OP_QMM:  m = OP_QM;
            OP_GMM:  m = OP_GM;
            default: m = OP_AM;
        endcase
        return m;
    endfunction

    // Second basic mean of a compound code.
    function automatic logic [3:0] second_mean(input logic [3:0] op);
        logic [3:0] m;
        case (op)
            OP_AGM:  m = OP_GM;
            OP_GHM:  m = OP_HM;
            OP_AHM:  m = OP_HM;
            OP_QAM:  m = OP_AM;
            OP_QGM:  m = OP_GM;
            OP_QMM:  m = OP_MM;
            OP_GMM:  m = OP_MM;
            default: m = OP_AM;
        endcase
        return m;
    endfunction

endpackage

// ===== hdl/two_value_mean_engine_unit.sv =====
// Top level of the two-value mean engine: sequencer, shared multiplier and
// shared restoring divide / square-root step. Depends on tvme_pkg.
//
// The unit takes one beat at a time and is not ready until its result has
// been moved into the output register. Every mean is computed exactly on the
// raw Q16.16 integers with floor rounding. An arithmetic mean is a halved
// sum; quadratic and geometric means use the multiplier and then 32 root
// steps; the harmonic mean uses the multiplier and then 64 quotient steps;
// the minus-square mean uses the multiplier, 64 quotient steps and 32 root
// steps. A compound mean runs both of its basic means in every round and
// repeats for the configured round count (at most 99). The result then
// moves to the output register once any result held there is taken. The
// shared 66-bit subtract-and-compare step brings in one bit of quotient or
// root per cycle. Zero operands, undefined codes and a round count of zero
// go from the accepted beat straight to that final move and skip the
// computing states. A result waits in the output register, and the next
// beat is accepted while it waits.
module two_value_mean_engine_unit
    import tvme_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [COUNT_WIDTH-1:0] cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_beat_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_beat_t              m_data
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_START, ST_MUL_GO, ST_MUL_ADD, ST_DIV, ST_SQRT, ST_STEP, ST_FIN
    } state_t;

    state_t                 state_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] rounds_reg;
    logic                   basic_reg;
    logic                   half_reg;
    logic [3:0]             op_reg;
    logic [3:0]             code_reg;
    logic [31:0]            a_reg, b_reg, na_reg, mres_reg, res_reg;
    logic                   err_reg;
    logic [2:0]             step_reg;
    logic [63:0]            prod_reg;
    logic [64:0]            sq_reg;
    logic [63:0]            p_reg;
    logic [127:0]           n_reg;
    logic [65:0]            rem_reg;
    logic [63:0]            work_reg;
    logic [63:0]            root_reg;
    logic [64:0]            den_reg;
    logic [6:0]             iter_reg;
    logic                   m_valid_reg;
    out_beat_t              m_data_reg;

    logic [31:0]            mul_a, mul_b;
    logic [65:0]            alu_lhs, alu_rhs;
    logic [66:0]            alu_diff;
    logic                   alu_ge;
    logic [127:0]           n_full;
    logic [32:0]            pair_sum;
    logic [32:0]            in_sum;
    logic [32:0]            final_sum;
    logic [COUNT_WIDTH-1:0] rounds_cap;
    logic                   mul_last;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Operand selection of the shared 32x32 multiplier, one partial product
    // per step: a*a and b*b build the sum of squares, a*b the product, and
    // the last three steps square that 64-bit product in 32-bit halves.
    always_comb begin
        unique case (step_reg)
            3'd0:    begin mul_a = a_reg;         mul_b = a_reg;         end
            3'd1:    begin mul_a = b_reg;         mul_b = b_reg;         end
            3'd2:    begin mul_a = a_reg;         mul_b = b_reg;         end
            3'd3:    begin mul_a = p_reg[31:0];   mul_b = p_reg[31:0];   end
            3'd4:    begin mul_a = p_reg[63:32];  mul_b = p_reg[31:0];   end
            3'd5:    begin mul_a = p_reg[63:32];  mul_b = p_reg[63:32];  end
            default: begin mul_a = '0;            mul_b = '0;            end
        endcase
    end

    // Shared step unit: restoring division brings in one numerator bit, the
    // digit-by-digit root brings in two radicand bits against 4*root+1.
    always_comb begin
        if (state_reg == ST_SQRT) begin
            alu_lhs = {rem_reg[63:0], work_reg[63:62]};
            alu_rhs = {32'd0, root_reg[31:0], 2'b01};
        end else begin
            alu_lhs = {rem_reg[64:0], work_reg[63]};
            alu_rhs = {1'b0, den_reg};
        end
    end

    assign alu_diff   = {1'b0, alu_lhs} - {1'b0, alu_rhs};
    assign alu_ge     = ~alu_diff[66];
    assign n_full     = n_reg + {prod_reg, 64'd0};
    assign pair_sum   = {1'b0, a_reg} + {1'b0, b_reg};
    assign in_sum     = {1'b0, s_data.operand_x} + {1'b0, s_data.operand_y};
    assign final_sum  = {1'b0, na_reg} + {1'b0, mres_reg};
    assign rounds_cap = (count_reg > MAX_ROUNDS) ? MAX_ROUNDS : count_reg;
    assign mul_last   = (code_reg == OP_MM) ? (step_reg == 3'd5) : (step_reg == 3'd2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            count_reg   <= RESET_ROUNDS;
        end else begin
            if (cfg_we) begin
                count_reg <= cfg_wdata;
            end
            // The output register refills as it empties.
            if (state_reg == ST_FIN && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        a_reg    <= s_data.operand_x;
                        b_reg    <= s_data.operand_y;
                        op_reg   <= s_data.operation;
                        half_reg <= 1'b0;
                        err_reg  <= (s_data.operand_x == '0 || s_data.operand_y == '0);
                        if (s_data.operand_x == '0 || s_data.operand_y == '0) begin
                            res_reg   <= '0;
                            state_reg <= ST_FIN;
                        end else if (s_data.operation <= OP_MM) begin
                            basic_reg <= 1'b1;
                            code_reg  <= s_data.operation;
                            state_reg <= ST_START;
                        end else if (s_data.operation <= OP_GMM) begin
                            basic_reg <= 1'b0;
                            if (rounds_cap == '0) begin
                                res_reg   <= in_sum[32:1];
                                state_reg <= ST_FIN;
                            end else begin
                                rounds_reg <= rounds_cap;
                                code_reg   <= first_mean(s_data.operation);
                                state_reg  <= ST_START;
                            end
                        end else begin
                            res_reg   <= '0;
                            state_reg <= ST_FIN;
                        end
                    end
                end

                ST_START: begin
                    if (code_reg == OP_AM) begin
                        mres_reg  <= pair_sum[32:1];
                        state_reg <= ST_STEP;
                    end else begin
                        step_reg  <= 3'd0;
                        state_reg <= ST_MUL_GO;
                    end
                end

                ST_MUL_GO: begin
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= ST_MUL_ADD;
                end

                ST_MUL_ADD: begin
                    unique case (step_reg)
                        3'd0:    sq_reg <= {1'b0, prod_reg};
                        3'd1:    sq_reg <= sq_reg + {1'b0, prod_reg};
                        3'd2:    p_reg  <= prod_reg;
                        3'd3:    n_reg  <= {64'd0, prod_reg};
                        3'd4:    n_reg  <= n_reg + ({64'd0, prod_reg} << 33);
                        default: n_reg  <= n_full;
                    endcase
                    if (mul_last) begin
                        root_reg <= '0;
                        unique case (code_reg)
                            OP_QM: begin
                                // Largest r with 2*r*r <= x*x + y*y.
                                work_reg  <= sq_reg[64:1];
                                rem_reg   <= '0;
                                iter_reg  <= 7'd32;
                                state_reg <= ST_SQRT;
                            end
                            OP_GM: begin
                                work_reg  <= prod_reg;
                                rem_reg   <= '0;
                                iter_reg  <= 7'd32;
                                state_reg <= ST_SQRT;
                            end
                            OP_HM: begin
                                // Quotient 2*x*y / (x + y).
                                rem_reg   <= {65'd0, prod_reg[63]};
                                work_reg  <= {prod_reg[62:0], 1'b0};
                                den_reg   <= {32'd0, pair_sum};
                                iter_reg  <= 7'd64;
                                state_reg <= ST_DIV;
                            end
                            default: begin
                                // Quotient 2*(x*y)^2 / (x*x + y*y), root taken next.
                                rem_reg   <= {1'b0, n_full[127:63]};
                                work_reg  <= {n_full[62:0], 1'b0};
                                den_reg   <= sq_reg;
                                iter_reg  <= 7'd64;
                                state_reg <= ST_DIV;
                            end
                        endcase
                    end else begin
                        step_reg  <= step_reg + 3'd1;
                        state_reg <= ST_MUL_GO;
                    end
                end

                ST_DIV: begin
                    if (iter_reg == 7'd1 && code_reg == OP_MM) begin
                        work_reg  <= {root_reg[62:0], alu_ge};
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        iter_reg  <= 7'd32;
                        state_reg <= ST_SQRT;
                    end else begin
                        rem_reg  <= alu_ge ? alu_diff[65:0] : alu_lhs;
                        work_reg <= {work_reg[62:0], 1'b0};
                        root_reg <= {root_reg[62:0], alu_ge};
                        iter_reg <= iter_reg - 7'd1;
                        if (iter_reg == 7'd1) begin
                            mres_reg  <= {root_reg[30:0], alu_ge};
                            state_reg <= ST_STEP;
                        end
                    end
                end

                ST_SQRT: begin
                    rem_reg  <= alu_ge ? alu_diff[65:0] : alu_lhs;
                    work_reg <= {work_reg[61:0], 2'b00};
                    root_reg <= {root_reg[62:0], alu_ge};
                    iter_reg <= iter_reg - 7'd1;
                    if (iter_reg == 7'd1) begin
                        mres_reg  <= {root_reg[30:0], alu_ge};
                        state_reg <= ST_STEP;
                    end
                end

                ST_STEP: begin
                    if (basic_reg) begin
                        res_reg   <= mres_reg;
                        state_reg <= ST_FIN;
                    end else if (!half_reg) begin
                        na_reg    <= mres_reg;
                        half_reg  <= 1'b1;
                        code_reg  <= second_mean(op_reg);
                        state_reg <= ST_START;
                    end else begin
                        half_reg <= 1'b0;
                        a_reg    <= na_reg;
                        b_reg    <= mres_reg;
                        code_reg <= first_mean(op_reg);
                        if (rounds_reg == 7'd1) begin
                            res_reg   <= final_sum[32:1];
                            state_reg <= ST_FIN;
                        end else begin
                            rounds_reg <= rounds_reg - 7'd1;
                            state_reg  <= ST_START;
                        end
                    end
                end

                ST_FIN: begin
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg.mean_value  <= res_reg;
                        m_data_reg.input_error <= err_reg;
                        state_reg              <= ST_IDLE;
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/tvme_checker.sv =====
// Port-level checker for the two-value mean engine, bound to the top level.
// Depends on tvme_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tvme_checker
    import tvme_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_beat_t m_data
);

    `TVME_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "result beat right after reset")
    `TVME_ASSERT(a_error_zero, aclk, aresetn, (m_valid && m_data.input_error) |-> (m_data.mean_value == '0), "error beat carries a nonzero mean")
    `TVME_ASSERT(a_busy_after_accept, aclk, aresetn, (s_valid && s_ready) |=> !s_ready, "ready right after an accepted beat")
    `TVME_ASSERT(a_out_hold, aclk, aresetn, (m_valid && !m_ready) |=> (m_valid && $stable(m_data)), "stalled result beat changed")

endmodule

bind two_value_mean_engine_unit tvme_checker u_tvme_checker (.*);
